[hdl/encoder_setpoint_panel_controller_macros.svh]
// Assertion macros for the encoder setpoint panel controller.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef ENCODER_SETPOINT_PANEL_CONTROLLER_MACROS_SVH
`define ENCODER_SETPOINT_PANEL_CONTROLLER_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ESP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("esp assertion failed");
// Implication checked from one clock edge to the next.
`define ESP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esp assertion failed");
`else
`define ESP_ASSERT(lbl, prop)
`define ESP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hdl/esp_pkg.sv]
// Shared types and constants of the encoder setpoint panel controller.
// Used by the register block, the controller, the datapath and the top level.
package esp_pkg;

    // Encoder event codes.
    localparam logic [2:0] MODE_NONE         = 3'd0;
    localparam logic [2:0] MODE_SHORT_PRESS  = 3'd1;
    localparam logic [2:0] MODE_LONG_PRESS   = 3'd2;
    localparam logic [2:0] MODE_TURN_DOWN    = 3'd3;
    localparam logic [2:0] MODE_TURN_UP      = 3'd4;
    localparam logic [2:0] MODE_TURN_PRESSED = 3'd5;

    // Field selection codes.
    localparam logic [1:0] FIELD_NONE = 2'd0;
    localparam logic [1:0] FIELD_VOLT = 2'd1;
    localparam logic [1:0] FIELD_CURR = 2'd2;

    // Configuration register indexes.
    localparam int unsigned ADDR_BITS = 5;
    localparam logic [2:0] REG_VOLTAGE_LOW       = 3'd0;
    localparam logic [2:0] REG_VOLTAGE_HIGH      = 3'd1;
    localparam logic [2:0] REG_VOLTAGE_INCREMENT = 3'd2;
    localparam logic [2:0] REG_CURRENT_LOW       = 3'd3;
    localparam logic [2:0] REG_CURRENT_HIGH      = 3'd4;
    localparam logic [2:0] REG_CURRENT_INCREMENT = 3'd5;
    localparam logic [2:0] REG_EDITING_ALLOWED   = 3'd6;
    localparam logic [2:0] REG_MENU_AVAILABLE    = 3'd7;

    // Timing constants in milliseconds.
    localparam int unsigned FAST_TURN_MS     = 75;
    localparam int unsigned BLINK_MS         = 500;
    localparam int unsigned DOUBLE_CLICK_MS  = 1000;
    localparam int unsigned FAULT_RECHECK_MS = 1000;

    // Fast-turn step target and the remainder unit, two dividend bits per cycle.
    localparam logic [7:0] FAST_STEP = 8'd250;
    localparam logic [1:0] DIV_LAST  = 2'd3;

    typedef struct packed {
        logic [15:0] voltage_low;
        logic [15:0] voltage_high;
        logic [15:0] voltage_increment;
        logic [15:0] current_low;
        logic [15:0] current_high;
        logic [15:0] current_increment;
        logic        editing_allowed;
        logic        menu_available;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       eval;
        logic       div;
        logic [1:0] div_idx;
        logic       sum;
        logic       apply;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic use_div;
    } stat_t;

    typedef struct packed {
        logic        menu_request;
        logic        editing_now;
        logic        fault_latched;
        logic        mark_current;
        logic        mark_voltage;
        logic        enable_pin_written;
        logic        enable_pin;
        logic        request_output;
        logic [15:0] current_setpoint;
        logic [15:0] voltage_setpoint;
    } res_t;

endpackage

[hdl/esp_regs.sv]
// APB configuration registers of the panel controller.
// Depends on esp_pkg for the register indexes and the cfg_t struct.
module esp_regs
    import esp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_VOLTAGE_LOW:       cfg_next.voltage_low       = pwdata[15:0];
                REG_VOLTAGE_HIGH:      cfg_next.voltage_high      = pwdata[15:0];
                REG_VOLTAGE_INCREMENT: cfg_next.voltage_increment = pwdata[15:0];
                REG_CURRENT_LOW:       cfg_next.current_low       = pwdata[15:0];
                REG_CURRENT_HIGH:      cfg_next.current_high      = pwdata[15:0];
                REG_CURRENT_INCREMENT: cfg_next.current_increment = pwdata[15:0];
                REG_EDITING_ALLOWED:   cfg_next.editing_allowed   = pwdata[0];
                REG_MENU_AVAILABLE:    cfg_next.menu_available    = pwdata[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with the power-on defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.voltage_low       <= 16'd3300;
            cfg_reg.voltage_high      <= 16'd21000;
            cfg_reg.voltage_increment <= 16'd20;
            cfg_reg.current_low       <= 16'd1000;
            cfg_reg.current_high      <= 16'd3000;
            cfg_reg.current_increment <= 16'd50;
            cfg_reg.editing_allowed   <= 1'b1;
            cfg_reg.menu_available    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (reg_idx)
            REG_VOLTAGE_LOW:       prdata = {16'd0, cfg_reg.voltage_low};
            REG_VOLTAGE_HIGH:      prdata = {16'd0, cfg_reg.voltage_high};
            REG_VOLTAGE_INCREMENT: prdata = {16'd0, cfg_reg.voltage_increment};
            REG_CURRENT_LOW:       prdata = {16'd0, cfg_reg.current_low};
            REG_CURRENT_HIGH:      prdata = {16'd0, cfg_reg.current_high};
            REG_CURRENT_INCREMENT: prdata = {16'd0, cfg_reg.current_increment};
            REG_EDITING_ALLOWED:   prdata = {31'd0, cfg_reg.editing_allowed};
            REG_MENU_AVAILABLE:    prdata = {31'd0, cfg_reg.menu_available};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

[hdl/esp_ctrl.sv]
// Sequencing state machine of the panel controller.
// Depends on esp_pkg for the command and status structs.
module esp_ctrl
    import esp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_SUM,
        S_APPLY
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                cnt_next   = 2'd0;
                state_next = stat.use_div ? S_DIV : S_SUM;
            end
            S_DIV:
            begin
                cmd.div     = 1'b1;
                cmd.div_idx = cnt_reg;
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                // Commit only once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.apply      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, iteration counter and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/esp_dp.sv]
// Datapath of the panel controller: panel state, remainder unit, stepping and result.
// Depends on esp_pkg for codes, constants and the cfg, cmd, stat and result structs.
module esp_dp
    import esp_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  cfg_t        cfg,
    input  logic [31:0] now_ms,
    input  logic [2:0]  mode,
    input  logic        fault_interrupt,
    input  logic        fault_present,
    input  logic        gate_readback,
    output stat_t       stat,
    output res_t        res
);

    // Captured request.
    logic [TIME_BITS-1:0] now_reg;
    logic [2:0]           mode_reg;
    logic                 irq_reg;
    logic                 fnow_reg;
    logic                 gate_reg;

    // Panel state.
    logic [15:0]          volt_reg;
    logic [15:0]          amp_reg;
    logic [1:0]           chosen_reg;
    logic                 edit_reg;
    logic                 blink_reg;
    logic [TIME_BITS-1:0] blink_stamp_reg;
    logic [TIME_BITS-1:0] click_stamp_reg;
    logic                 fault_reg;
    logic [TIME_BITS-1:0] fault_stamp_reg;
    logic                 enable_reg;
    logic                 started_reg;
    logic                 pin_reg;

    // Working registers.
    logic                 use_div_reg;
    logic [7:0]           rem_reg;
    logic [7:0]           rem_next;
    logic [15:0]          sum_reg;
    logic [15:0]          sum_next;
    res_t                 res_reg;
    res_t                 res_next;

    // Shared decode.
    logic [TIME_BITS-1:0] el_fault;
    logic [TIME_BITS-1:0] el_blink;
    logic [TIME_BITS-1:0] el_click;
    logic                 is_turn;
    logic                 turn_up;
    logic                 field_volt;
    logic [15:0]          sel_inc;
    logic [15:0]          sel_low;
    logic [15:0]          sel_high;
    logic                 use_div;

    // Remainder unit.
    logic [7:0]           div_bits;
    logic [16:0]          inc_ext;
    logic [16:0]          trial_a;
    logic [16:0]          part_a;
    logic [16:0]          trial_b;
    logic [16:0]          part_b;

    // Stepping.
    logic [15:0]          base;
    logic [15:0]          step;
    logic signed [17:0]   raw;
    logic signed [17:0]   lo_s;
    logic signed [17:0]   hi_s;
    logic signed [17:0]   above_lo;
    logic signed [17:0]   clamped;

    // Commit logic.
    logic                 fault_hit;
    logic                 fault_a;
    logic [TIME_BITS-1:0] fstamp_a;
    logic                 enable_a;
    logic                 pin_a;
    logic                 recheck;
    logic                 fault_b;
    logic [TIME_BITS-1:0] fstamp_b;
    logic                 req_a;
    logic                 blink_toggle;
    logic                 blink_n;
    logic [TIME_BITS-1:0] bstamp_n;
    logic                 active;
    logic                 edit_n;
    logic                 req_n;
    logic                 menu_n;
    logic                 started_n;
    logic [TIME_BITS-1:0] click_n;
    logic                 enable_n;
    logic                 pin_n;
    logic                 written_n;
    logic [1:0]           chosen_n;
    logic [15:0]          volt_n;
    logic [15:0]          amp_n;

    // Next field when the selection is turned through none, voltage and current.
    function automatic logic [1:0] field_rotate(input logic [1:0] field, input logic up);
        logic [1:0] nxt;
        begin
            case (field)
                FIELD_NONE: nxt = up ? FIELD_VOLT : FIELD_CURR;
                FIELD_VOLT: nxt = up ? FIELD_CURR : FIELD_NONE;
                FIELD_CURR: nxt = up ? FIELD_NONE : FIELD_VOLT;
                default:    nxt = up ? FIELD_VOLT : FIELD_CURR;
            endcase
            return nxt;
        end
    endfunction

    // Elapsed times, wrapping at the time width.
    assign el_fault = now_reg - fault_stamp_reg;
    assign el_blink = now_reg - blink_stamp_reg;
    assign el_click = now_reg - click_stamp_reg;

    // Event and field decode.
    assign is_turn    = (mode_reg == MODE_TURN_DOWN) || (mode_reg == MODE_TURN_UP);
    assign turn_up    = (mode_reg == MODE_TURN_UP);
    assign field_volt = (chosen_reg == FIELD_VOLT);
    assign sel_inc    = field_volt ? cfg.voltage_increment : cfg.current_increment;
    assign sel_low    = field_volt ? cfg.voltage_low : cfg.current_low;
    assign sel_high   = field_volt ? cfg.voltage_high : cfg.current_high;

    // A fast turn on an edited field needs the step 250 rounded down to the increment.
    assign use_div = is_turn && cfg.editing_allowed && edit_reg
                     && ((chosen_reg == FIELD_VOLT) || (chosen_reg == FIELD_CURR))
                     && (el_click <= TIME_BITS'(FAST_TURN_MS))
                     && (sel_inc != 16'd0);
    assign stat.use_div = use_div;

    // Restoring remainder of 250 by the increment, two dividend bits per cycle.
    assign div_bits = FAST_STEP << {cmd.div_idx, 1'b0};
    assign inc_ext  = {1'b0, sel_inc};
    assign trial_a  = {8'd0, rem_reg, div_bits[7]};
    assign part_a   = (trial_a >= inc_ext) ? (trial_a - inc_ext) : trial_a;
    assign trial_b  = {8'd0, part_a[7:0], div_bits[6]};
    assign part_b   = (trial_b >= inc_ext) ? (trial_b - inc_ext) : trial_b;
    assign rem_next = part_b[7:0];

    // Signed step and clamp; the high limit wins over the low one.
    assign base = field_volt
                  ? (started_reg ? volt_reg : cfg.voltage_low)
                  : (started_reg ? amp_reg : cfg.current_low);
    assign step = use_div_reg ? {8'd0, FAST_STEP - rem_reg} : sel_inc;
    assign raw  = turn_up ? ({2'b00, base} + {2'b00, step}) : ({2'b00, base} - {2'b00, step});
    assign lo_s = {2'b00, sel_low};
    assign hi_s = {2'b00, sel_high};
    assign above_lo = (raw < lo_s) ? lo_s : raw;
    assign clamped  = (above_lo > hi_s) ? hi_s : above_lo;
    assign sum_next = clamped[15:0];

    // Fault interrupt, then the periodic fault recheck.
    assign fault_hit = irq_reg && fnow_reg;
    assign fault_a   = irq_reg ? fnow_reg : fault_reg;
    assign fstamp_a  = fault_hit ? now_reg : fault_stamp_reg;
    assign enable_a  = fault_hit ? 1'b0 : enable_reg;
    assign pin_a     = fault_hit ? 1'b0 : pin_reg;
    assign recheck   = !irq_reg && fault_reg && (el_fault >= TIME_BITS'(FAULT_RECHECK_MS));
    assign fault_b   = recheck ? fnow_reg : fault_a;
    assign fstamp_b  = recheck ? now_reg : fstamp_a;
    assign req_a     = !started_reg || (recheck && !fnow_reg);

    // Blink phase and the highlight taken before the event.
    assign blink_toggle = edit_reg && (el_blink >= TIME_BITS'(BLINK_MS));
    assign blink_n      = blink_reg ^ blink_toggle;
    assign bstamp_n     = blink_toggle ? now_reg : blink_stamp_reg;
    assign active       = edit_reg ? blink_n : 1'b1;

    // Event handling.
    always_comb
    begin
        edit_n    = edit_reg;
        req_n     = req_a;
        menu_n    = 1'b0;
        started_n = 1'b1;
        click_n   = click_stamp_reg;
        enable_n  = enable_a;
        pin_n     = pin_a;
        written_n = fault_hit;
        chosen_n  = chosen_reg;
        volt_n    = started_reg ? volt_reg : cfg.voltage_low;
        amp_n     = started_reg ? amp_reg : cfg.current_low;
        case (mode_reg)
            MODE_SHORT_PRESS:
            begin
                if (chosen_reg != FIELD_NONE)
                begin
                    if (!edit_reg)
                    begin
                        edit_n = 1'b1;
                    end
                    else
                    begin
                        req_n  = 1'b1;
                        edit_n = 1'b0;
                    end
                end
                else if (cfg.menu_available && !enable_a)
                begin
                    // Double click with nothing selected and the output off.
                    if (el_click <= TIME_BITS'(DOUBLE_CLICK_MS))
                    begin
                        menu_n    = 1'b1;
                        started_n = 1'b0;
                    end
                    click_n = now_reg;
                end
            end
            MODE_LONG_PRESS:
            begin
                if (!edit_reg && !fault_b)
                begin
                    enable_n  = !enable_a;
                    pin_n     = gate_reg;
                    written_n = 1'b1;
                end
            end
            MODE_TURN_DOWN, MODE_TURN_UP:
            begin
                if (cfg.editing_allowed)
                begin
                    if (edit_reg)
                    begin
                        click_n = now_reg;
                        if (chosen_reg == FIELD_VOLT)
                        begin
                            volt_n = sum_reg;
                        end
                        else if (chosen_reg == FIELD_CURR)
                        begin
                            amp_n = sum_reg;
                        end
                    end
                    else
                    begin
                        chosen_n = field_rotate(chosen_reg, turn_up);
                    end
                end
            end
            default:
            begin
                edit_n = edit_reg;
            end
        endcase
    end

    // Result assembly.
    always_comb
    begin
        res_next.voltage_setpoint   = volt_n;
        res_next.current_setpoint   = amp_n;
        res_next.request_output     = req_n;
        res_next.enable_pin         = pin_n;
        res_next.enable_pin_written = written_n;
        res_next.mark_voltage       = (chosen_reg == FIELD_VOLT) && active;
        res_next.mark_current       = (chosen_reg == FIELD_CURR) && active;
        res_next.fault_latched      = fault_b;
        res_next.editing_now        = edit_n;
        res_next.menu_request       = menu_n;
    end

    assign res = res_reg;

    // Request capture and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg  <= TIME_BITS'(now_ms);
            mode_reg <= mode;
            irq_reg  <= fault_interrupt;
            fnow_reg <= fault_present;
            gate_reg <= gate_readback;
        end
        if (cmd.eval)
        begin
            use_div_reg <= use_div;
            rem_reg     <= 8'd0;
        end
        if (cmd.div)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.sum)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.apply)
        begin
            res_reg <= res_next;
        end
    end

    // Panel state, committed once per request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_reg        <= 16'd0;
            amp_reg         <= 16'd0;
            chosen_reg      <= FIELD_NONE;
            edit_reg        <= 1'b0;
            blink_reg       <= 1'b0;
            blink_stamp_reg <= '0;
            click_stamp_reg <= '0;
            fault_reg       <= 1'b0;
            fault_stamp_reg <= '0;
            enable_reg      <= 1'b0;
            started_reg     <= 1'b0;
            pin_reg         <= 1'b0;
        end
        else if (cmd.apply)
        begin
            volt_reg        <= volt_n;
            amp_reg         <= amp_n;
            chosen_reg      <= chosen_n;
            edit_reg        <= edit_n;
            blink_reg       <= blink_n;
            blink_stamp_reg <= bstamp_n;
            click_stamp_reg <= click_n;
            fault_reg       <= fault_b;
            fault_stamp_reg <= fstamp_b;
            enable_reg      <= enable_n;
            started_reg     <= started_n;
            pin_reg         <= pin_n;
        end
    end

endmodule

[hdl/encoder_setpoint_panel_controller.sv]
// Channel   Dir  Handshake            Contents
// s_*       in   s_tvalid / s_tready  time, fault flags, gate readback; event code in tuser
// m_*       out  m_tvalid / m_tready  setpoints, output request, pin, marks, flags
// APB       in   psel/penable/pready  eight configuration registers at 4-byte spacing
//
// A request without a fast turn passes through capture, decode, step and clamp, and commit
// before the next acceptance. A fast turn in edit mode adds the remainder unit, which works
// two dividend bits per cycle, between decode and step.
// The commit waits while an earlier result is still held in the output register.
// Reset returns the panel state to idle and the registers to their defaults; no clearing pass.
`include "encoder_setpoint_panel_controller_macros.svh"
module encoder_setpoint_panel_controller
    import esp_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] now_ms, [32] fault_interrupt, [33] fault_present, [34] gate_readback
    input  logic [39:0]          s_tdata,
    // [2:0] mode
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] voltage_setpoint, [31:16] current_setpoint, [32] request_output,
    // [33] enable_pin, [34] enable_pin_written, [35] mark_voltage,
    // [36] mark_current, [37] fault_latched, [38] editing_now, [39] menu_request
    output logic [39:0]          m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;
    res_t  res;

    // Configuration registers.
    esp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencing.
    esp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Panel state and arithmetic.
    esp_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg             (cfg),
        .now_ms          (s_tdata[31:0]),
        .mode            (s_tuser),
        .fault_interrupt (s_tdata[32]),
        .fault_present   (s_tdata[33]),
        .gate_readback   (s_tdata[34]),
        .stat            (stat),
        .res             (res)
    );

    // The result struct is laid out in output order, lowest field last.
    assign m_tdata = res;

    // A request that has just been taken keeps the input closed.
    `ESP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // A commit never overwrites a result that is still waiting.
    `ESP_ASSERT(a_no_overwrite, !cmd.apply || !m_tvalid || m_tready)
    // The controller issues at most one command per cycle.
    `ESP_ASSERT(a_one_command, $onehot0({cmd.load, cmd.eval, cmd.div, cmd.sum, cmd.apply}))
    // The remainder unit only runs for a fast turn.
    `ESP_ASSERT_NEXT(a_div_follows_eval, cmd.eval && !stat.use_div, !cmd.div)

endmodule

[dv/tb_top.sv]
// Self-checking testbench of the encoder setpoint panel controller.
// Depends on esp_pkg and the top level; runs a directed table, then random phases
// under several register settings, and checks every result against its model or the table.
module tb_top
    import esp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Event codes that the package leaves unnamed; the block ignores them.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned PHASE_COUNT    = 8;
    localparam int unsigned PHASE_REQUESTS = 180;
    localparam int unsigned PRINT_CAP      = 40;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now;
        logic        irq;
        logic        fault;
        logic        gate;
        logic        typed;
        res_t        want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // [31:0] now_ms, [32] fault_interrupt, [33] fault_present, [34] gate_readback
    logic [39:0]          s_tdata;
    // [2:0] mode
    logic [2:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // [15:0] voltage_setpoint, [31:16] current_setpoint, [32] request_output,
    // [33] enable_pin, [34] enable_pin_written, [35] mark_voltage,
    // [36] mark_current, [37] fault_latched, [38] editing_now, [39] menu_request
    logic [39:0]          m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // Panel model: registers and state as the block should hold them.
    cfg_t        panel_cfg;
    logic [15:0] volt_sp;
    logic [15:0] amp_sp;
    logic [1:0]  field_sel;
    bit          editing;
    bit          blink_on;
    bit          fault_on;
    bit          output_on;
    bit          pin_state;
    bit          panel_live;
    logic [31:0] blink_mark;
    logic [31:0] click_mark;
    logic [31:0] fault_mark;

    // Outputs still owed by the block, oldest first.
    res_t        due_outputs[$];

    // Side information for the request on the bus, set by the driver.
    bit          drive_typed;
    res_t        drive_want;

    int unsigned mismatches;
    int unsigned checked;
    int unsigned requests_sent;
    int unsigned fast_steps;
    int unsigned menu_hits;
    int unsigned cycles;

    encoder_setpoint_panel_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task automatic flag_mismatch(input string what, input longint unsigned got_v,
                                 input longint unsigned want_v);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("Mismatch at cycle %0d: %s got %0d, want %0d", cycles, what, got_v,
                     want_v);
    endtask

    function automatic logic [31:0] elapsed_ms(input logic [31:0] now,
                                               input logic [31:0] stamp);
        return now - stamp;
    endfunction

    // One detent step with fast-turn scaling, summed signed and clamped, high limit last.
    function automatic logic [15:0] step_setpoint(input logic [15:0] value,
                                                  input logic [15:0] inc,
                                                  input logic [15:0] lo,
                                                  input logic [15:0] hi,
                                                  input bit fast, input bit up);
        longint mult;
        longint v;
        mult = 1;
        if (fast && inc != 16'd0)
            mult = longint'(FAST_STEP) / longint'(inc);
        if (up)
            v = longint'(value) + longint'(inc) * mult;
        else
            v = longint'(value) - longint'(inc) * mult;
        if (v < longint'(lo))
            v = longint'(lo);
        if (v > longint'(hi))
            v = longint'(hi);
        return v[15:0];
    endfunction

    // Advances the panel model by one request and returns the outputs it owes.
    function automatic res_t panel_step(input logic [31:0] now, input logic [2:0] mode,
                                        input bit irq, input bit fault_now, input bit gate);
        res_t r;
        bit   req;
        bit   written;
        bit   menu;
        bit   active;
        bit   fast;
        bit   up;
        req     = 1'b0;
        written = 1'b0;
        menu    = 1'b0;

        // First request after reset or after a menu request loads the low limits.
        if (!panel_live)
        begin
            panel_live = 1'b1;
            volt_sp    = panel_cfg.voltage_low;
            amp_sp     = panel_cfg.current_low;
            req        = 1'b1;
        end

        // Fault interrupt and periodic recheck share the one status sample.
        if (irq)
        begin
            fault_on = fault_now;
            if (fault_now)
            begin
                fault_mark = now;
                output_on  = 1'b0;
                pin_state  = 1'b0;
                written    = 1'b1;
            end
        end
        if (fault_on && elapsed_ms(now, fault_mark) >= FAULT_RECHECK_MS)
        begin
            fault_mark = now;
            if (!fault_now)
            begin
                fault_on = 1'b0;
                req      = 1'b1;
            end
        end

        // Blink, then the highlight as it stands before the event.
        if (editing && elapsed_ms(now, blink_mark) >= BLINK_MS)
        begin
            blink_mark = now;
            blink_on   = !blink_on;
        end
        active = editing ? blink_on : 1'b1;
        r.mark_voltage = (field_sel == FIELD_VOLT) && active;
        r.mark_current = (field_sel == FIELD_CURR) && active;

        case (mode)
            MODE_SHORT_PRESS:
            begin
                if (field_sel != FIELD_NONE)
                begin
                    if (!editing)
                        editing = 1'b1;
                    else
                    begin
                        req     = 1'b1;
                        editing = 1'b0;
                    end
                end
                else if (panel_cfg.menu_available && !output_on)
                begin
                    if (elapsed_ms(now, click_mark) <= DOUBLE_CLICK_MS)
                    begin
                        menu       = 1'b1;
                        panel_live = 1'b0;
                        menu_hits++;
                    end
                    click_mark = now;
                end
            end
            MODE_LONG_PRESS:
            begin
                if (!editing && !fault_on)
                begin
                    output_on = !output_on;
                    pin_state = gate;
                    written   = 1'b1;
                end
            end
            MODE_TURN_DOWN, MODE_TURN_UP:
            begin
                if (panel_cfg.editing_allowed)
                begin
                    up = (mode == MODE_TURN_UP);
                    if (editing)
                    begin
                        fast       = elapsed_ms(now, click_mark) <= FAST_TURN_MS;
                        click_mark = now;
                        if (fast && field_sel != FIELD_NONE)
                            fast_steps++;
                        if (field_sel == FIELD_VOLT)
                            volt_sp = step_setpoint(volt_sp, panel_cfg.voltage_increment,
                                                    panel_cfg.voltage_low,
                                                    panel_cfg.voltage_high, fast, up);
                        else if (field_sel == FIELD_CURR)
                            amp_sp = step_setpoint(amp_sp, panel_cfg.current_increment,
                                                   panel_cfg.current_low,
                                                   panel_cfg.current_high, fast, up);
                    end
                    else if (up)
                        field_sel = (field_sel == FIELD_CURR) ? FIELD_NONE : field_sel + 2'd1;
                    else
                        field_sel = (field_sel == FIELD_NONE) ? FIELD_CURR : field_sel - 2'd1;
                end
            end
            default:
            begin
            end
        endcase

        r.voltage_setpoint   = volt_sp;
        r.current_setpoint   = amp_sp;
        r.request_output     = req;
        r.enable_pin         = pin_state;
        r.enable_pin_written = written;
        r.fault_latched      = fault_on;
        r.editing_now        = editing;
        r.menu_request       = menu;
        return r;
    endfunction

    // Register write as seen on the bus, masked to the register's width.
    task automatic apply_register(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_VOLTAGE_LOW:       panel_cfg.voltage_low       = value[15:0];
            REG_VOLTAGE_HIGH:      panel_cfg.voltage_high      = value[15:0];
            REG_VOLTAGE_INCREMENT: panel_cfg.voltage_increment = value[15:0];
            REG_CURRENT_LOW:       panel_cfg.current_low       = value[15:0];
            REG_CURRENT_HIGH:      panel_cfg.current_high      = value[15:0];
            REG_CURRENT_INCREMENT: panel_cfg.current_increment = value[15:0];
            REG_EDITING_ALLOWED:   panel_cfg.editing_allowed   = value[0];
            REG_MENU_AVAILABLE:    panel_cfg.menu_available    = value[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_panel(input res_t got, input res_t want);
        if (got.voltage_setpoint !== want.voltage_setpoint)
            flag_mismatch("voltage_setpoint", got.voltage_setpoint, want.voltage_setpoint);
        if (got.current_setpoint !== want.current_setpoint)
            flag_mismatch("current_setpoint", got.current_setpoint, want.current_setpoint);
        if (got.request_output !== want.request_output)
            flag_mismatch("request_output", got.request_output, want.request_output);
        if (got.enable_pin !== want.enable_pin)
            flag_mismatch("enable_pin", got.enable_pin, want.enable_pin);
        if (got.enable_pin_written !== want.enable_pin_written)
            flag_mismatch("enable_pin_written", got.enable_pin_written,
                          want.enable_pin_written);
        if (got.mark_voltage !== want.mark_voltage)
            flag_mismatch("mark_voltage", got.mark_voltage, want.mark_voltage);
        if (got.mark_current !== want.mark_current)
            flag_mismatch("mark_current", got.mark_current, want.mark_current);
        if (got.fault_latched !== want.fault_latched)
            flag_mismatch("fault_latched", got.fault_latched, want.fault_latched);
        if (got.editing_now !== want.editing_now)
            flag_mismatch("editing_now", got.editing_now, want.editing_now);
        if (got.menu_request !== want.menu_request)
            flag_mismatch("menu_request", got.menu_request, want.menu_request);
    endtask

    // Bus monitor: results are checked before new requests are predicted, and
    // register writes update the model at the edge the block takes them.
    always @(posedge clk)
    begin : bus_monitor
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (due_outputs.size() == 0)
                    flag_mismatch("result with nothing owed, voltage_setpoint",
                                  got.voltage_setpoint, 0);
                else
                begin
                    want = due_outputs.pop_front();
                    compare_panel(got, want);
                    checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = panel_step(s_tdata[31:0], s_tuser, s_tdata[32], s_tdata[33],
                                  s_tdata[34]);
                if (drive_typed)
                    want = drive_want;
                due_outputs.push_back(want);
            end
            if (psel && penable && pwrite && pready)
                apply_register(paddr[ADDR_BITS-1:2], pwdata);
        end
    end

    // Result side: a random stall before each result, with quiet stretches.
    initial
    begin : result_sink
        int unsigned stall;
        int unsigned taken;
        taken    = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = ((taken / 56) % 4 == 1) ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

    // Drives one request after a random gap; returns at the falling edge after
    // acceptance with tvalid still high.
    task automatic send_request(input row_t row);
        int unsigned gap;
        gap = ((requests_sent / 48) % 4 == 2) ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata     = {5'b0, row.gate, row.fault, row.irq, row.now};
        s_tuser     = row.mode;
        drive_typed = row.typed;
        drive_want  = row.want;
        s_tvalid    = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    function automatic row_t mk_row(input logic [2:0] mode, input logic [31:0] now,
                                    input bit irq, input bit fault, input bit gate,
                                    input bit typed, input res_t want);
        row_t row;
        row.mode  = mode;
        row.now   = now;
        row.irq   = irq;
        row.fault = fault;
        row.gate  = gate;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic cfg_t mk_cfg(input logic [15:0] vlo, input logic [15:0] vhi,
                                    input logic [15:0] vinc, input logic [15:0] clo,
                                    input logic [15:0] chi, input logic [15:0] cinc,
                                    input bit edit_ok, input bit menu_ok);
        cfg_t c;
        c.voltage_low       = vlo;
        c.voltage_high      = vhi;
        c.voltage_increment = vinc;
        c.current_low       = clo;
        c.current_high      = chi;
        c.current_increment = cinc;
        c.editing_allowed   = edit_ok;
        c.menu_available    = menu_ok;
        return c;
    endfunction

    // Bus write, setup then access; unused upper data bits carry noise when asked.
    task automatic write_register(input logic [2:0] idx, input logic [15:0] value,
                                  input bit noisy);
        logic [31:0] noise;
        noise   = noisy ? $urandom : 32'd0;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = (idx == REG_EDITING_ALLOWED || idx == REG_MENU_AVAILABLE)
                  ? {noise[31:1], value[0]} : {noise[31:16], value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_settings(input cfg_t c, input bit noisy);
        write_register(REG_VOLTAGE_LOW, c.voltage_low, noisy);
        write_register(REG_VOLTAGE_HIGH, c.voltage_high, noisy);
        write_register(REG_VOLTAGE_INCREMENT, c.voltage_increment, noisy);
        write_register(REG_CURRENT_LOW, c.current_low, noisy);
        write_register(REG_CURRENT_HIGH, c.current_high, noisy);
        write_register(REG_CURRENT_INCREMENT, c.current_increment, noisy);
        write_register(REG_EDITING_ALLOWED, {15'd0, c.editing_allowed}, noisy);
        write_register(REG_MENU_AVAILABLE, {15'd0, c.menu_available}, noisy);
    endtask

    // Lowers the request line and waits until every owed result has come back.
    task automatic drain_results();
        s_tvalid    = 1'b0;
        drive_typed = 1'b0;
        while (due_outputs.size() != 0)
            @(negedge clk);
    endtask

    // Random request: weighted events and time steps that favour fast turns,
    // blink and double-click windows, the fault recheck period and wrap-around.
    function automatic row_t random_row(input logic [31:0] now);
        int unsigned pick;
        logic [2:0]  mode;
        logic [31:0] delta;
        pick = $urandom_range(0, 99);
        if (pick < 8)       mode = MODE_NONE;
        else if (pick < 26) mode = MODE_SHORT_PRESS;
        else if (pick < 34) mode = MODE_LONG_PRESS;
        else if (pick < 60) mode = MODE_TURN_DOWN;
        else if (pick < 88) mode = MODE_TURN_UP;
        else if (pick < 94) mode = MODE_TURN_PRESSED;
        else if (pick < 97) mode = MODE_SPARE_6;
        else                mode = MODE_SPARE_7;
        pick = $urandom_range(0, 99);
        if (pick < 45)      delta = $urandom_range(0, 80);
        else if (pick < 75) delta = $urandom_range(81, 700);
        else if (pick < 93) delta = $urandom_range(900, 1100);
        else if (pick < 98) delta = $urandom_range(0, 100000);
        else                delta = $urandom;
        return mk_row(mode, now + delta, $urandom_range(0, 99) < 8,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
    endfunction

    initial
    begin : stimulus
        row_t        table_rows[$];
        cfg_t        settings[PHASE_COUNT];
        res_t        w;
        row_t        row;
        logic [31:0] clock_ms;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = MODE_NONE;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        drive_typed = 1'b0;
        drive_want  = '0;
        mismatches  = 0;
        checked     = 0;
        requests_sent = 0;
        fast_steps  = 0;
        menu_hits   = 0;
        cycles      = 0;

        // Model state after reset.
        panel_cfg  = mk_cfg(16'd3300, 16'd21000, 16'd20, 16'd1000, 16'd3000, 16'd50,
                            1'b1, 1'b0);
        volt_sp    = '0;
        amp_sp     = '0;
        field_sel  = FIELD_NONE;
        editing    = 1'b0;
        blink_on   = 1'b0;
        fault_on   = 1'b0;
        output_on  = 1'b0;
        pin_state  = 1'b0;
        panel_live = 1'b0;
        blink_mark = '0;
        click_mark = '0;
        fault_mark = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table under the reset settings. The first request loads the low
        // limits and asks for output; the first turn selects voltage, marks still clear.
        w = '0;
        w.voltage_setpoint = 16'd3300;
        w.current_setpoint = 16'd1000;
        w.request_output   = 1'b1;
        table_rows.push_back(mk_row(MODE_NONE, 32'd0, 0, 0, 0, 1'b1, w));
        w.request_output   = 1'b0;
        table_rows.push_back(mk_row(MODE_TURN_UP, 32'd100, 0, 0, 0, 1'b1, w));
        // Edit voltage: slow and fast steps, then down to the low limit and below it.
        table_rows.push_back(mk_row(MODE_SHORT_PRESS, 32'd200, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_TURN_UP, 32'd300, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_TURN_UP, 32'd340, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_TURN_DOWN, 32'd360, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_TURN_DOWN, 32'd500, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_TURN_DOWN, 32'd600, 0, 0, 0, 1'b0, '0));
        // Blink toggle, ignored events and a long press that editing blocks.
        table_rows.push_back(mk_row(MODE_NONE, 32'd1200, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_TURN_PRESSED, 32'd1300, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_SPARE_6, 32'd1400, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_SPARE_7, 32'd1500, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_LONG_PRESS, 32'd1600, 0, 0, 1, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_SHORT_PRESS, 32'd1700, 0, 0, 0, 1'b0, '0));
        // Current field: select, edit, step, leave, then turn down through voltage to none.
        table_rows.push_back(mk_row(MODE_TURN_UP, 32'd1800, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_SHORT_PRESS, 32'd1900, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_TURN_UP, 32'd2000, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_SHORT_PRESS, 32'd2100, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_TURN_DOWN, 32'd2200, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_TURN_DOWN, 32'd2300, 0, 0, 0, 1'b0, '0));
        // Output on, fault latch forcing it off, blocked toggle, recheck clearing it.
        table_rows.push_back(mk_row(MODE_LONG_PRESS, 32'd2400, 0, 0, 1, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_NONE, 32'd2500, 1, 1, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_LONG_PRESS, 32'd2600, 0, 1, 1, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_NONE, 32'd3600, 0, 0, 0, 1'b0, '0));
        table_rows.push_back(mk_row(MODE_SHORT_PRESS, 32'hFFFF_FFFF, 1, 0, 1, 1'b0, '0));
        foreach (table_rows[i])
            send_request(table_rows[i]);
        drain_results();

        // Register settings per phase: defaults with the menu, full range with unit
        // and widest steps, low above high with zero step, steps beyond the fast
        // target, editing locked, two random sets, then the reset values again.
        settings[0] = mk_cfg(16'd3300, 16'd21000, 16'd20, 16'd1000, 16'd3000, 16'd50,
                             1'b1, 1'b1);
        settings[1] = mk_cfg(16'd0, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        settings[2] = mk_cfg(16'd5000, 16'd100, 16'd0, 16'hFFFF, 16'hFFFF, 16'd250,
                             1'b1, 1'b1);
        settings[3] = mk_cfg(16'd1000, 16'd30000, 16'd251, 16'd1000, 16'd2000, 16'd125,
                             1'b1, 1'b0);
        settings[4] = mk_cfg(16'd3000, 16'd4000, 16'd7, 16'd0, 16'd9, 16'd3, 1'b0, 1'b1);
        for (int p = 5; p < 7; p++)
        begin
            settings[p].voltage_low       = 16'($urandom_range(0, 30000));
            settings[p].voltage_high      = 16'($urandom_range(0, 65535));
            settings[p].voltage_increment = 16'($urandom_range(1, 400));
            settings[p].current_low       = 16'($urandom_range(0, 30000));
            settings[p].current_high      = 16'($urandom_range(0, 65535));
            settings[p].current_increment = 16'($urandom_range(0, 65535));
            settings[p].editing_allowed   = 1'b1;
            settings[p].menu_available    = 1'($urandom_range(0, 1));
        end
        settings[7] = mk_cfg(16'd3300, 16'd21000, 16'd20, 16'd1000, 16'd3000, 16'd50,
                             1'b1, 1'b0);

        clock_ms = 32'hFFFF_FFFF;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            load_settings(settings[p], p >= 5);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                row      = random_row(clock_ms);
                clock_ms = row.now;
                send_request(row);
            end
            drain_results();
        end

        repeat (16) @(posedge clk);
        $display("Sent %0d requests over %0d register settings; %0d results checked.",
                 requests_sent, PHASE_COUNT + 1, checked);
        $display("Model saw %0d fast steps and %0d menu requests; %0d mismatches.",
                 fast_steps, menu_hits, mismatches);
        if (mismatches == 0 && due_outputs.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
